// ----- sv/icodp_pkg.sv -----
package icodp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_ENTRIES
  } phase_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_NO_IMAGES  = 3'd2;
  localparam logic [2:0] ST_TRUNCATED  = 3'd3;
  localparam logic [2:0] ST_OUT_BOUNDS = 3'd4;

  localparam int unsigned HdrLen   = 6;
  localparam int unsigned EntryLen = 16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] num_images;
    logic [15:0] chosen_index;
    logic [8:0]  chosen_width;
    logic [8:0]  chosen_height;
    logic [15:0] chosen_depth;
    logic [31:0] chosen_offset;
    logic [31:0] chosen_length;
  } out_word_t;

  // width or height byte of zero stands for 256
  function automatic logic [8:0] dim_decode(input logic [7:0] b);
    dim_decode = (b == 8'd0) ? 9'd256 : {1'b0, b};
  endfunction

endpackage

// ----- sv/icodp_parser.sv -----
module icodp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  icodp_pkg::in_word_t in_word,
  input  logic [31:0]         file_length,
  output logic                res_valid,
  output icodp_pkg::out_word_t res
);

  // control state
  icodp_pkg::phase_t phase, phase_next;
  logic [20:0] pos, pos_next;
  logic [3:0]  slot, slot_next;
  logic [15:0] cnt, cnt_next;
  logic [15:0] total, total_next;
  logic [16:0] best_area, best_area_next;
  logic [15:0] best_depth, best_depth_next;
  logic [15:0] best_index, best_index_next;
  logic [8:0]  best_width, best_width_next;
  logic [8:0]  best_height, best_height_next;
  logic [31:0] best_offset, best_offset_next;
  logic [31:0] best_length, best_length_next;

  // byte assembly for header / entry, every slot written before it is read
  logic [7:0] asm_bytes [icodp_pkg::EntryLen];

  // view of state after an optional restart on this word
  icodp_pkg::phase_t eff_phase;
  logic [20:0] eff_pos;
  logic [3:0]  eff_slot;
  logic [15:0] eff_cnt, eff_total, eff_depth, eff_index;
  logic [16:0] eff_area;
  logic [8:0]  eff_width, eff_height;
  logic [31:0] eff_offset, eff_length;

  logic        start;
  logic [7:0]  b;
  logic        active, trunc, in_hdr, in_ent;
  logic        hdr_last, hdr_bad;
  logic [15:0] hdr_total;
  logic        ent_last, ent_oob, better, take, done_ok;
  logic [8:0]  ent_w, ent_h;
  logic [15:0] ent_bpp;
  logic [31:0] ent_size, ent_off;
  logic [32:0] ent_end;
  logic [17:0] ent_prod;
  logic [16:0] ent_area;
  logic [15:0] cnt_inc;
  logic        f_trunc, f_bad, f_none, f_oob, f_ok;

  assign start = in_word.file_start;
  assign b     = in_word.data_byte;

  assign eff_phase  = start ? icodp_pkg::PH_HEADER : phase;
  assign eff_pos    = start ? '0 : pos;
  assign eff_slot   = start ? '0 : slot;
  assign eff_cnt    = start ? '0 : cnt;
  assign eff_total  = start ? '0 : total;
  assign eff_area   = start ? '0 : best_area;
  assign eff_depth  = start ? '0 : best_depth;
  assign eff_index  = start ? '0 : best_index;
  assign eff_width  = start ? '0 : best_width;
  assign eff_height = start ? '0 : best_height;
  assign eff_offset = start ? '0 : best_offset;
  assign eff_length = start ? '0 : best_length;

  assign active = accept && (eff_phase != icodp_pkg::PH_IDLE);
  assign trunc  = ({11'd0, eff_pos} >= file_length);
  assign in_hdr = active && !trunc && (eff_phase == icodp_pkg::PH_HEADER);
  assign in_ent = active && !trunc && (eff_phase == icodp_pkg::PH_ENTRIES);

  // header completes on its sixth byte, which is the count's high byte
  assign hdr_last  = (eff_pos == 21'(icodp_pkg::HdrLen - 1));
  assign hdr_total = {b, asm_bytes[4]};
  assign hdr_bad   = ({asm_bytes[1], asm_bytes[0]} != 16'd0) ||
                     ({asm_bytes[3], asm_bytes[2]} != 16'd1);

  // entry completes on its last byte, the top of the offset
  assign ent_last = (eff_slot == 4'(icodp_pkg::EntryLen - 1));
  assign ent_w    = icodp_pkg::dim_decode(asm_bytes[0]);
  assign ent_h    = icodp_pkg::dim_decode(asm_bytes[1]);
  assign ent_bpp  = {asm_bytes[7], asm_bytes[6]};
  assign ent_size = {asm_bytes[11], asm_bytes[10], asm_bytes[9], asm_bytes[8]};
  assign ent_off  = {b, asm_bytes[14], asm_bytes[13], asm_bytes[12]};
  assign ent_end  = {1'b0, ent_off} + {1'b0, ent_size};
  assign ent_oob  = (ent_end > {1'b0, file_length});
  assign ent_prod = ent_w * ent_h;
  assign ent_area = ent_prod[16:0];
  assign better   = (ent_area >= eff_area) && (ent_bpp > eff_depth);
  assign take     = (eff_cnt == 16'd0) || better;
  assign cnt_inc  = eff_cnt + 16'd1;
  assign done_ok  = (cnt_inc == eff_total);

  assign f_trunc = active && trunc;
  assign f_bad   = in_hdr && hdr_last && hdr_bad;
  assign f_none  = in_hdr && hdr_last && !hdr_bad && (hdr_total == 16'd0);
  assign f_oob   = in_ent && ent_last && ent_oob;
  assign f_ok    = in_ent && ent_last && !ent_oob && done_ok;

  // next state
  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    slot_next        = slot;
    cnt_next         = cnt;
    total_next       = total;
    best_area_next   = best_area;
    best_depth_next  = best_depth;
    best_index_next  = best_index;
    best_width_next  = best_width;
    best_height_next = best_height;
    best_offset_next = best_offset;
    best_length_next = best_length;
    if (accept) begin
      phase_next       = eff_phase;
      pos_next         = eff_pos;
      slot_next        = eff_slot;
      cnt_next         = eff_cnt;
      total_next       = eff_total;
      best_area_next   = eff_area;
      best_depth_next  = eff_depth;
      best_index_next  = eff_index;
      best_width_next  = eff_width;
      best_height_next = eff_height;
      best_offset_next = eff_offset;
      best_length_next = eff_length;
      if (f_trunc) begin
        phase_next = icodp_pkg::PH_IDLE;
      end else if (in_hdr) begin
        pos_next = eff_pos + 21'd1;
        if (hdr_last) begin
          total_next = hdr_total;
          slot_next  = '0;
          if (f_bad || f_none) begin
            phase_next = icodp_pkg::PH_IDLE;
          end else begin
            phase_next = icodp_pkg::PH_ENTRIES;
          end
        end
      end else if (in_ent) begin
        pos_next  = eff_pos + 21'd1;
        slot_next = eff_slot + 4'd1;
        if (ent_last) begin
          if (ent_oob) begin
            phase_next = icodp_pkg::PH_IDLE;
          end else begin
            if (take) begin
              best_index_next  = eff_cnt;
              best_width_next  = ent_w;
              best_height_next = ent_h;
              best_offset_next = ent_off;
              best_length_next = ent_size;
            end
            if (better) begin
              best_area_next  = ent_area;
              best_depth_next = ent_bpp;
            end
            cnt_next = cnt_inc;
            if (done_ok) begin
              phase_next = icodp_pkg::PH_IDLE;
            end
          end
        end
      end
    end
  end

  // result word
  always_comb begin
    res_valid = f_trunc || f_bad || f_none || f_oob || f_ok;
    res       = '0;
    if (f_trunc) begin
      res.status     = icodp_pkg::ST_TRUNCATED;
      res.num_images = eff_total;
    end else if (f_bad) begin
      res.status     = icodp_pkg::ST_BAD_HEADER;
      res.num_images = hdr_total;
    end else if (f_none) begin
      res.status     = icodp_pkg::ST_NO_IMAGES;
      res.num_images = hdr_total;
    end else if (f_oob) begin
      res.status     = icodp_pkg::ST_OUT_BOUNDS;
      res.num_images = eff_total;
    end else if (f_ok) begin
      res.status        = icodp_pkg::ST_OK;
      res.num_images    = eff_total;
      res.chosen_index  = best_index_next;
      res.chosen_width  = best_width_next;
      res.chosen_height = best_height_next;
      res.chosen_depth  = best_depth_next;
      res.chosen_offset = best_offset_next;
      res.chosen_length = best_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= icodp_pkg::PH_IDLE;
      pos         <= '0;
      slot        <= '0;
      cnt         <= '0;
      total       <= '0;
      best_area   <= '0;
      best_depth  <= '0;
      best_index  <= '0;
      best_width  <= '0;
      best_height <= '0;
      best_offset <= '0;
      best_length <= '0;
    end else begin
      phase       <= phase_next;
      pos         <= pos_next;
      slot        <= slot_next;
      cnt         <= cnt_next;
      total       <= total_next;
      best_area   <= best_area_next;
      best_depth  <= best_depth_next;
      best_index  <= best_index_next;
      best_width  <= best_width_next;
      best_height <= best_height_next;
      best_offset <= best_offset_next;
      best_length <= best_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_hdr) begin
      asm_bytes[{1'b0, eff_pos[2:0]}] <= b;
    end else if (in_ent) begin
      asm_bytes[eff_slot] <= b;
    end
  end

endmodule

// ----- sv/icodp_out_buf.sv -----
module icodp_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  icodp_pkg::out_word_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output icodp_pkg::out_word_t out_data
);

  // main output register plus one skid slot
  logic                 skid_valid;
  icodp_pkg::out_word_t skid_data;
  logic                 pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

// ----- sv/ico_directory_parser.sv -----
// Icon file directory parser. Takes one file byte per word, at up to one word
// per clock; the header/entry fields are assembled in place and each entry is
// checked and ranked in the cycle its last byte arrives, so a result word is
// registered from the byte that finishes the directory or fails a
// check. Results sit in a two-deep output register; in_ready drops only while
// both slots hold results that have not been taken. After a result, bytes are
// dropped until a word with file_start set. file_length (cfg_we/cfg_wdata)
// resets to 0 and should be written before the file is streamed.
module ico_directory_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  icodp_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output icodp_pkg::out_word_t out_data,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);

  logic [31:0]          file_length;
  logic                 accept;
  logic                 res_valid;
  icodp_pkg::out_word_t res;
  logic                 buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
    end else if (cfg_we) begin
      file_length <= cfg_wdata;
    end
  end

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  icodp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_word     (in_data),
    .file_length (file_length),
    .res_valid   (res_valid),
    .res         (res)
  );

  icodp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sv/icodp_checker.sv -----
module icodp_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input icodp_pkg::out_word_t out_data
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // error results carry no chosen entry
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != icodp_pkg::ST_OK) |->
      (out_data.chosen_index == 16'd0) && (out_data.chosen_width == 9'd0) &&
      (out_data.chosen_height == 9'd0) && (out_data.chosen_depth == 16'd0) &&
      (out_data.chosen_offset == 32'd0) && (out_data.chosen_length == 32'd0))
    else $error("chosen fields set on error result");

  // a good result names an entry inside the directory
  a_ok_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == icodp_pkg::ST_OK) |->
      (out_data.num_images != 16'd0) &&
      (out_data.chosen_index < out_data.num_images))
    else $error("chosen index outside directory");

  // a good result has decoded nonzero geometry
  a_ok_geom: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == icodp_pkg::ST_OK) |->
      (out_data.chosen_width != 9'd0) && (out_data.chosen_height != 9'd0))
    else $error("zero geometry on good result");

  // input is refused only while results are backed up
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with output empty");

endmodule

bind ico_directory_parser icodp_checker u_icodp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- test/tb_ico_directory_parser.sv -----
module tb_ico_directory_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LimitNs    = 5_000_000;
  localparam int unsigned ItemCount  = 1450;
  localparam int unsigned HoldCycles = 300;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  icodp_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  icodp_pkg::out_word_t out_data;
  logic                 cfg_we;
  logic [31:0]          cfg_wdata;

  // shadow copy of the parser
  logic [31:0]       file_len;
  icodp_pkg::phase_t ph;
  logic [20:0]       pos;
  logic [63:0]       acc_lo;
  logic [63:0]       acc_hi;
  logic [15:0]       n_total;
  logic [15:0]       n_seen;
  logic [16:0]       best_area;
  logic [15:0]       best_depth;
  logic [15:0]       best_idx;
  logic [8:0]        best_w;
  logic [8:0]        best_h;
  logic [31:0]       best_off;
  logic [31:0]       best_size;

  icodp_pkg::out_word_t verdict_q[$];
  logic [7:0]           file_bytes[$];
  int unsigned          words_sent;
  int unsigned          mismatches = 0;
  bit                   calm_tx;
  bit                   calm_rx;
  int unsigned          hold_count;

  ico_directory_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parse();
    ph         = icodp_pkg::PH_IDLE;
    pos        = '0;
    acc_lo     = '0;
    acc_hi     = '0;
    n_total    = '0;
    n_seen     = '0;
    best_area  = '0;
    best_depth = '0;
    best_idx   = '0;
    best_w     = '0;
    best_h     = '0;
    best_off   = '0;
    best_size  = '0;
  endfunction

  function automatic void close_file(logic [2:0] st);
    icodp_pkg::out_word_t v;
    v = '0;
    v.status     = st;
    v.num_images = n_total;
    if (st == icodp_pkg::ST_OK) begin
      v.chosen_index  = best_idx;
      v.chosen_width  = best_w;
      v.chosen_height = best_h;
      v.chosen_depth  = best_depth;
      v.chosen_offset = best_off;
      v.chosen_length = best_size;
    end
    verdict_q.push_back(v);
    ph = icodp_pkg::PH_IDLE;
  endfunction

  function automatic void rank_entry();
    logic [8:0]  ew;
    logic [8:0]  eh;
    logic [15:0] bpp;
    logic [31:0] sz;
    logic [31:0] off;
    logic [17:0] prod;
    logic [16:0] area;
    logic        better;
    ew  = (acc_lo[7:0] == 8'd0) ? 9'd256 : {1'b0, acc_lo[7:0]};
    eh  = (acc_lo[15:8] == 8'd0) ? 9'd256 : {1'b0, acc_lo[15:8]};
    bpp = acc_lo[63:48];
    sz  = acc_hi[31:0];
    off = acc_hi[63:32];
    acc_lo = '0;
    acc_hi = '0;
    // 33-bit sum, no wrap
    if ({1'b0, off} + {1'b0, sz} > {1'b0, file_len}) begin
      close_file(icodp_pkg::ST_OUT_BOUNDS);
      return;
    end
    prod   = ew * eh;
    area   = prod[16:0];
    better = (area >= best_area) && (bpp > best_depth);
    // entry 0 always seeds the pick, even with depth 0
    if (n_seen == 16'd0 || better) begin
      best_idx  = n_seen;
      best_w    = ew;
      best_h    = eh;
      best_off  = off;
      best_size = sz;
    end
    if (better) begin
      best_area  = area;
      best_depth = bpp;
    end
    n_seen = n_seen + 16'd1;
    if (n_seen == n_total) close_file(icodp_pkg::ST_OK);
  endfunction

  function automatic void predict_word(icodp_pkg::in_word_t w);
    logic [3:0] k;
    if (w.file_start) begin
      clear_parse();
      ph = icodp_pkg::PH_HEADER;
    end
    if (ph == icodp_pkg::PH_IDLE) return;
    if ({11'd0, pos} >= file_len) begin
      close_file(icodp_pkg::ST_TRUNCATED);
      return;
    end
    if (ph == icodp_pkg::PH_HEADER) begin
      acc_lo = acc_lo | (64'(w.data_byte) << (8 * pos[2:0]));
      pos = pos + 21'd1;
      if (pos == 21'(icodp_pkg::HdrLen)) begin
        n_total = acc_lo[47:32];
        if (acc_lo[15:0] != 16'd0 || acc_lo[31:16] != 16'd1) begin
          close_file(icodp_pkg::ST_BAD_HEADER);
        end else if (n_total == 16'd0) begin
          close_file(icodp_pkg::ST_NO_IMAGES);
        end else begin
          ph = icodp_pkg::PH_ENTRIES;
        end
        acc_lo = '0;
      end
      return;
    end
    k = 4'(pos - 21'(icodp_pkg::HdrLen));
    if (k[3]) acc_hi = acc_hi | (64'(w.data_byte) << (8 * k[2:0]));
    else acc_lo = acc_lo | (64'(w.data_byte) << (8 * k[2:0]));
    pos = pos + 21'd1;
    if (k == 4'd15) rank_entry();
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      note_mismatch($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got));
  endfunction

  function automatic void check_verdict(icodp_pkg::out_word_t got);
    icodp_pkg::out_word_t want;
    if (verdict_q.size() == 0) begin
      note_mismatch($sformatf("unexpected result word: %p", got));
      return;
    end
    want = verdict_q.pop_front();
    cmp_field("status", 32'(want.status), 32'(got.status));
    cmp_field("num_images", 32'(want.num_images), 32'(got.num_images));
    cmp_field("chosen_index", 32'(want.chosen_index), 32'(got.chosen_index));
    cmp_field("chosen_width", 32'(want.chosen_width), 32'(got.chosen_width));
    cmp_field("chosen_height", 32'(want.chosen_height), 32'(got.chosen_height));
    cmp_field("chosen_depth", 32'(want.chosen_depth), 32'(got.chosen_depth));
    cmp_field("chosen_offset", want.chosen_offset, got.chosen_offset);
    cmp_field("chosen_length", want.chosen_length, got.chosen_length);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_verdict(out_data);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_count != hold_taken) begin
        hold_taken = hold_count;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm_rx || ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_word(logic [7:0] b, bit start);
    icodp_pkg::in_word_t w;
    w.data_byte  = b;
    w.file_start = start;
    @(negedge clk);
    if (!calm_tx) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    predict_word(w);
  endtask

  // wait out every pending result, then the block's latency
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_file_length(logic [31:0] v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    file_len = v;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic void add_le(logic [31:0] v, int unsigned nb);
    for (int unsigned i = 0; i < nb; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_header(logic [15:0] res, logic [15:0] typ, logic [15:0] cnt);
    add_le(32'(res), 2);
    add_le(32'(typ), 2);
    add_le(32'(cnt), 2);
  endfunction

  function automatic void add_entry(logic [7:0] w, logic [7:0] h, logic [7:0] colors,
                                    logic [7:0] resv, logic [15:0] planes, logic [15:0] bpp,
                                    logic [31:0] sz, logic [31:0] off);
    add_le(32'(w), 1);
    add_le(32'(h), 1);
    add_le(32'(colors), 1);
    add_le(32'(resv), 1);
    add_le(32'(planes), 2);
    add_le(32'(bpp), 2);
    add_le(sz, 4);
    add_le(off, 4);
  endfunction

  task automatic stream_file(int unsigned lo_idx, int unsigned hi_idx);
    for (int unsigned i = lo_idx; i < hi_idx; i++) send_word(file_bytes[i], i == 0);
  endtask

  task automatic stream_all();
    stream_file(0, file_bytes.size());
    file_bytes.delete();
  endtask

  // length is still 0 out of reset: stray bytes are dropped, any file truncates at once
  task automatic test_idle_and_empty_file();
    send_word(8'($urandom), 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    settle();
  endtask

  task automatic test_header_checks();
    write_file_length(32'hFFFF_FFFF);
    add_header(16'h0001, 16'h0001, 16'h0001);
    stream_all();
    add_header(16'h0000, 16'h0002, 16'h0003);
    stream_all();
    // bad words win over a zero count
    add_header(16'hFFFF, 16'hFFFF, 16'h0000);
    stream_all();
    add_header(16'h0000, 16'h0001, 16'h0000);
    stream_all();
    settle();
  endtask

  task automatic test_entry_extremes();
    write_file_length(32'hFFFF_FFFF);
    add_header(16'h0000, 16'h0001, 16'h0002);
    add_entry(8'h00, 8'h00, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    add_entry(8'h01, 8'h01, 8'h00, 8'h00, 16'h0000, 16'h0000, 32'h0, 32'hFFFF_FFFF);
    stream_all();
    // offset plus size one past the end, only visible without wrap
    add_header(16'h0000, 16'h0001, 16'h0001);
    add_entry(8'h80, 8'h7F, 8'h10, 8'h00, 16'h0001, 16'h0020, 32'h1, 32'hFFFF_FFFF);
    stream_all();
    settle();
  endtask

  task automatic test_depth_ranking();
    write_file_length(32'h0000_1000);
    // no entry with depth: entry 0 stays chosen
    add_header(16'h0000, 16'h0001, 16'h0003);
    add_entry(8'd16, 8'd16, 8'd0, 8'd0, 16'd1, 16'd0, 32'h40, 32'h100);
    add_entry(8'd32, 8'd32, 8'd0, 8'd0, 16'd1, 16'd0, 32'h80, 32'h200);
    add_entry(8'd48, 8'd48, 8'd0, 8'd0, 16'd1, 16'd0, 32'h80, 32'h300);
    stream_all();
    // equal area with more depth wins; smaller area or equal depth does not
    add_header(16'h0000, 16'h0001, 16'h0004);
    add_entry(8'd32, 8'd32, 8'd0, 8'd0, 16'd1, 16'd8, 32'h10, 32'h100);
    add_entry(8'd32, 8'd32, 8'd0, 8'd0, 16'd1, 16'd32, 32'h20, 32'h200);
    add_entry(8'd16, 8'd16, 8'd0, 8'd0, 16'd1, 16'd64, 32'h30, 32'h300);
    add_entry(8'd64, 8'd64, 8'd0, 8'd0, 16'd1, 16'd32, 32'h40, 32'h400);
    stream_all();
    settle();
  endtask

  task automatic test_restart();
    write_file_length(32'h0000_1000);
    add_header(16'h0000, 16'h0001, 16'h0001);
    add_entry(8'd24, 8'd24, 8'd0, 8'd0, 16'd1, 16'd24, 32'h100, 32'h200);
    stream_file(0, 11);
    file_bytes.delete();
    add_header(16'h0000, 16'h0001, 16'h0001);
    add_entry(8'd48, 8'd0, 8'd0, 8'd0, 16'd1, 16'd32, 32'h180, 32'h300);
    stream_all();
    // payload bytes after the result are dropped
    send_word(8'h89, 1'b0);
    send_word(8'h50, 1'b0);
    settle();
  endtask

  task automatic test_truncation();
    write_file_length(32'd30);
    add_header(16'h0000, 16'h0001, 16'h0002);
    add_entry(8'd16, 8'd16, 8'd0, 8'd0, 16'd1, 16'd8, 32'd4, 32'd20);
    add_entry(8'd32, 8'd32, 8'd0, 8'd0, 16'd1, 16'd8, 32'd4, 32'd20);
    stream_all();
    write_file_length(32'd40);
    add_header(16'h0000, 16'h0001, 16'hFFFF);
    repeat (3) add_entry(8'd1, 8'd2, 8'd0, 8'd0, 16'd1, 16'd4, 32'd0, 32'd40);
    stream_all();
    // cut inside the header: count not known yet
    write_file_length(32'd3);
    add_header(16'h0000, 16'h0001, 16'h0001);
    stream_all();
    settle();
  endtask

  task automatic test_midfile_length_change();
    write_file_length(32'h0010_0000);
    add_header(16'h0000, 16'h0001, 16'h0002);
    add_entry(8'd32, 8'd32, 8'd0, 8'd0, 16'd1, 16'd8, 32'h100, 32'h100);
    add_entry(8'd64, 8'd64, 8'd0, 8'd0, 16'd1, 16'd32, 32'h80, 32'h200);
    stream_file(0, icodp_pkg::HdrLen + icodp_pkg::EntryLen);
    // shrink the file between entries: the second one no longer fits
    write_file_length(32'h0000_0250);
    stream_file(icodp_pkg::HdrLen + icodp_pkg::EntryLen, file_bytes.size());
    file_bytes.delete();
    settle();
  endtask

  task automatic test_output_backpressure();
    write_file_length(32'h0000_FFFF);
    calm_tx = 1'b1;
    hold_count++;
    repeat (12) begin
      add_header(16'($urandom_range(65535, 1)), 16'($urandom), 16'($urandom));
      stream_all();
    end
    calm_tx = 1'b0;
    settle();
  endtask

  task automatic random_file();
    int unsigned pick;
    int unsigned n;
    int unsigned dir_len;
    int unsigned sel;
    int unsigned cut;
    logic [15:0] res;
    logic [15:0] typ;
    logic [15:0] cnt;
    logic [15:0] bpp;
    logic [31:0] lim;
    logic [31:0] off;
    logic [31:0] sz;
    pick    = $urandom_range(99);
    n       = ($urandom_range(9) == 0) ? $urandom_range(12, 4) : $urandom_range(3, 1);
    dir_len = icodp_pkg::HdrLen + icodp_pkg::EntryLen * n;
    sel     = $urandom_range(9);
    if (sel < 5) begin
      lim = $urandom;
      if (lim < dir_len) lim = dir_len;
      write_file_length(lim);
    end else if (sel < 7) begin
      write_file_length(dir_len + $urandom_range(2, 0));
    end else if (sel < 8) begin
      write_file_length($urandom_range(dir_len - 1, 0));
    end
    lim = file_len;
    res = 16'h0000;
    typ = 16'h0001;
    cnt = 16'(n);
    if (pick < 6) res = 16'($urandom);
    else if (pick < 12) typ = 16'($urandom);
    else if (pick < 15) cnt = 16'h0000;
    else if (pick < 19) cnt = 16'($urandom_range(65535, n + 1));
    add_header(res, typ, cnt);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(11) == 0) begin
        off = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FF00);
        sz  = $urandom_range(32'hFFFF_FFFF, 32'h0000_0100);
      end else begin
        off = $urandom_range(lim, 0);
        sz  = $urandom_range(lim - off, 0);
      end
      case ($urandom_range(5))
        0:       bpp = 16'd0;
        1:       bpp = 16'd1;
        2:       bpp = 16'd8;
        3:       bpp = 16'd24;
        4:       bpp = 16'd32;
        default: bpp = 16'($urandom);
      endcase
      add_entry(($urandom_range(7) == 0) ? 8'd0 : 8'($urandom),
                ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom),
                8'($urandom), 8'($urandom), 16'($urandom), bpp, sz, off);
    end
    cut = (pick >= 19 && pick < 27) ? $urandom_range(file_bytes.size() - 1, 1)
                                    : file_bytes.size();
    stream_file(0, cut);
    file_bytes.delete();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(4, 1)) send_word(8'($urandom), 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned files;
    files = 0;
    while (words_sent < ItemCount) begin
      // one stretch with both sides running flat out
      calm_tx = (files >= 12 && files < 20);
      calm_rx = calm_tx;
      if ($urandom_range(9) == 0) begin
        send_word(8'($urandom), 1'b1);
        repeat ($urandom_range(40, 5)) send_word(8'($urandom), $urandom_range(15) == 0);
      end else begin
        random_file();
      end
      files++;
    end
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    settle();
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    calm_tx    = 1'b0;
    calm_rx    = 1'b0;
    hold_count = 0;
    words_sent = 0;
    file_len   = '0;
    clear_parse();
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_idle_and_empty_file();
    test_header_checks();
    test_entry_extremes();
    test_depth_ranking();
    test_restart();
    test_truncation();
    test_midfile_length_change();
    test_output_backpressure();
    test_random_traffic();

    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #LimitNs;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- ico_directory_parser.f -----
sv/icodp_pkg.sv
sv/icodp_parser.sv
sv/icodp_out_buf.sv
sv/ico_directory_parser.sv
sv/icodp_checker.sv
test/tb_ico_directory_parser.sv
